### src/pfm_pkg.sv
package pfm_pkg;

    // Field and register widths
    localparam int unsigned VAL_W     = 38;
    localparam int unsigned COEF_W    = 32;
    localparam int unsigned POS_W     = 6;
    localparam int unsigned COORD_W   = 16;
    localparam int unsigned CNT_W     = 7;
    localparam int unsigned PER_W     = 13;
    localparam int unsigned GRID_W    = 7;
    localparam int unsigned FOLD_W    = 12;
    localparam int unsigned DIFF_W    = 18;
    localparam int unsigned MAG_W     = 17;
    localparam int unsigned CFG_IDX_W = 1;

    // Register reset values and limits
    localparam logic [PER_W-1:0]  PERIOD_RST = 13'd64;
    localparam logic [PER_W-1:0]  PERIOD_LIM = 13'd4096;
    localparam logic [GRID_W-1:0] GRID_RST   = 7'd64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID   = 1'b1;

    // Input actions
    localparam logic ACT_MASK  = 1'b0;
    localparam logic ACT_COEFF = 1'b1;

    typedef struct packed {
        logic                      action;
        logic [POS_W-1:0]          position;
        logic                      mask_bit;
        logic signed [COEF_W-1:0]  coeff;
        logic signed [COORD_W-1:0] center_coord;
        logic signed [COORD_W-1:0] lower_bound;
        logic [CNT_W-1:0]          coeff_count;
        logic                      last_coeff;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        grid_position;
        logic                    last;
        logic                    empty_res;
    } t_out_item;

endpackage

### src/pfm_stream_if.sv
interface pfm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/pfm_ram.sv
module pfm_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read-first: a read at the address being written returns the old word
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### src/pfm_mod.sv
module pfm_mod (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [pfm_pkg::DIFF_W-1:0] i_diff,
    input  logic [pfm_pkg::PER_W-1:0]         i_period,
    output logic                              o_done,
    output logic [pfm_pkg::FOLD_W-1:0]        o_rem
);
    import pfm_pkg::*;

    localparam int STEP_W = $clog2(MAG_W);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [MAG_W-1:0]    r_mag;
    logic [PER_W-1:0]    r_rem;
    logic                r_neg;
    logic [FOLD_W-1:0]   r_res;

    logic [DIFF_W-1:0]   w_abs;
    logic [PER_W:0]      w_trial;
    logic [PER_W:0]      w_reduced;
    logic [PER_W-1:0]    n_rem;
    logic [PER_W-1:0]    w_fix;

    always_comb begin
        w_abs     = i_diff[DIFF_W-1] ? (~i_diff + DIFF_W'(1)) : i_diff;
        w_trial   = {r_rem, r_mag[MAG_W-1]};
        w_reduced = (w_trial >= {1'b0, i_period}) ? (w_trial - {1'b0, i_period}) : w_trial;
        n_rem     = w_reduced[PER_W-1:0];
        // True modulo: a negative dividend with nonzero remainder folds up
        w_fix     = (r_neg && (n_rem != '0)) ? (i_period - n_rem) : n_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == STEP_W'(MAG_W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= '0;
            r_mag  <= w_abs[MAG_W-1:0];
            r_rem  <= '0;
            r_neg  <= i_diff[DIFF_W-1];
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            r_mag  <= {r_mag[MAG_W-2:0], 1'b0};
            r_rem  <= n_rem;
            if (r_step == STEP_W'(MAG_W - 1)) begin
                r_res <= w_fix[FOLD_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_res;
endmodule

### src/periodic_fold_and_mask_compact.sv
// Mask item: taken in IDLE, and the block stays in IDLE. First coefficient of a job:
// input held while the 17-step remainder unit finds the fold start. Further
// coefficients: taken back to back, one read-modify-write of the accumulator RAM
// each (none for a dropped position), with forwarding of the prior write. Last
// coefficient: input held through DRAIN, the SCAN/DATA walk of kept positions, FLUSH
// and output stalls. Reset (synchronous, active low): config to 64/64, keep bits
module periodic_fold_and_mask_compact #(
    parameter int GRID_MAX = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pfm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pfm_pkg::PER_W-1:0]         i_cfg_data,
    pfm_stream_if.sink                        i_in,
    pfm_stream_if.source                      o_out
);
    // and job state cleared.
    import pfm_pkg::*;

    localparam int AW = $clog2(GRID_MAX);
    localparam int IW = AW + 1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_START = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_DATA  = 6'b010000,
        ST_FLUSH = 6'b100000
    } t_state;

    t_state               r_state;
    t_state               n_state;

    // Configuration
    logic [PER_W-1:0]     r_period;
    logic [GRID_W-1:0]    r_grid;
    logic [PER_W-1:0]     w_p_eff;
    logic [IW-1:0]        w_g_eff;

    // Per-position flags: keep bits, and "written this job" marks that stand
    // in for clearing the accumulator RAM at job start
    logic [GRID_MAX-1:0]  r_keep;
    logic [GRID_MAX-1:0]  r_touch;

    logic                 r_job_open;
    logic [FOLD_W-1:0]    r_fold;

    // First coefficient parked while the start position is computed
    logic signed [COEF_W-1:0] r_first_coeff;
    logic                 r_first_last;

    // Write-back stage of the read-modify-write
    logic                 r_s1_valid;
    logic [AW-1:0]        r_s1_addr;
    logic signed [COEF_W-1:0] r_s1_coeff;

    // Last write, kept for forwarding past the read-first RAM
    logic                 r_wr_valid;
    logic [AW-1:0]        r_wr_addr;
    logic [VAL_W-1:0]     r_wr_data;

    // Walk
    logic [IW-1:0]        r_idx;
    logic                 r_hold_valid;
    logic [VAL_W-1:0]     r_hold_value;
    logic [POS_W-1:0]     r_hold_pos;

    logic                 r_out_valid;
    t_out_item            r_out;

    // Handshake and decode
    logic                 w_acc;
    logic                 w_acc_mask;
    logic                 w_acc_coeff;
    logic                 w_mod_start;
    logic                 w_mod_done;
    logic [FOLD_W-1:0]    w_mod_rem;
    logic [CNT_W-1:0]     w_cnt_m1;
    logic [CNT_W-2:0]     w_half;
    logic signed [DIFF_W-1:0] w_diff;
    logic [AW-1:0]        w_keep_addr;

    // Coefficient issue
    logic                 w_issue;
    logic                 w_issue_hit;
    logic [FOLD_W-1:0]    w_issue_fold;
    logic signed [COEF_W-1:0] w_issue_coeff;
    logic [PER_W-1:0]     w_fold_inc;
    logic [FOLD_W-1:0]    w_fold_next;

    // Accumulate
    logic [VAL_W-1:0]     w_base;
    logic [VAL_W-1:0]     w_sum;

    // Walk decode
    logic                 w_scan_in;
    logic                 w_scan_keep;
    logic                 w_data_leave;
    logic [VAL_W-1:0]     w_data_val;
    logic                 w_out_free;

    // RAM port
    logic                 w_re;
    logic [AW-1:0]        w_raddr;
    logic [VAL_W-1:0]     w_rdata;

    // ---------------------------------------------------------------------
    // Effective configuration: zero period acts as one, clamp both ranges
    // ---------------------------------------------------------------------
    always_comb begin
        if (r_period == '0) begin
            w_p_eff = PER_W'(1);
        end else if (r_period > PERIOD_LIM) begin
            w_p_eff = PERIOD_LIM;
        end else begin
            w_p_eff = r_period;
        end
        w_g_eff = (32'(r_grid) > GRID_MAX) ? IW'(GRID_MAX) : IW'(r_grid);
    end

    // ---------------------------------------------------------------------
    // Input decode. A transfer is taken only in IDLE.
    // ---------------------------------------------------------------------
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_acc_mask  = w_acc && (i_in.payload.action == ACT_MASK);
    assign w_acc_coeff = w_acc && (i_in.payload.action == ACT_COEFF);
    assign w_mod_start = w_acc_coeff && !r_job_open;
    assign w_keep_addr = AW'(i_in.payload.position);

    // Fold start offset: center - lower - (count-1)/2, count zero gives zero
    always_comb begin
        w_cnt_m1 = i_in.payload.coeff_count - CNT_W'(1);
        w_half   = (i_in.payload.coeff_count == '0) ? '0 : w_cnt_m1[CNT_W-1:1];
        w_diff   = DIFF_W'(i_in.payload.center_coord) - DIFF_W'(i_in.payload.lower_bound)
                 - DIFF_W'(w_half);
    end

    pfm_mod u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mod_start),
        .i_diff   (w_diff),
        .i_period (w_p_eff),
        .o_done   (w_mod_done),
        .o_rem    (w_mod_rem)
    );

    // ---------------------------------------------------------------------
    // Coefficient issue: read the accumulator at the fold position, advance
    // the fold with wrap at the period. Positions at or past the kept grid
    // length drop.
    // ---------------------------------------------------------------------
    always_comb begin
        w_issue       = (w_acc_coeff && r_job_open) || ((r_state == ST_START) && w_mod_done);
        w_issue_fold  = (r_state == ST_START) ? w_mod_rem : r_fold;
        w_issue_coeff = (r_state == ST_START) ? r_first_coeff : i_in.payload.coeff;
        w_issue_hit   = w_issue && (32'(w_issue_fold) < 32'(w_g_eff));
        w_fold_inc    = PER_W'(w_issue_fold) + PER_W'(1);
        w_fold_next   = (w_fold_inc >= w_p_eff) ? '0 : w_fold_inc[FOLD_W-1:0];
    end

    // Write-back: unwritten entries read as zero; forward the write of the
    // previous cycle, which the read-first RAM did not yet return
    always_comb begin
        if (!r_touch[r_s1_addr]) begin
            w_base = '0;
        end else if (r_wr_valid && (r_wr_addr == r_s1_addr)) begin
            w_base = r_wr_data;
        end else begin
            w_base = w_rdata;
        end
        w_sum = w_base + {{(VAL_W - COEF_W){r_s1_coeff[COEF_W-1]}}, r_s1_coeff};
    end

    // ---------------------------------------------------------------------
    // Walk decode
    // ---------------------------------------------------------------------
    always_comb begin
        w_out_free   = !r_out_valid || o_out.ready;
        w_scan_in    = 32'(r_idx) < 32'(w_g_eff);
        w_scan_keep  = w_scan_in && r_keep[r_idx[AW-1:0]];
        w_data_leave = !r_hold_valid || w_out_free;
        w_data_val   = r_touch[r_idx[AW-1:0]] ? w_rdata : '0;
    end

    assign w_re    = w_issue_hit || ((r_state == ST_SCAN) && w_scan_keep);
    assign w_raddr = (r_state == ST_SCAN) ? r_idx[AW-1:0] : w_issue_fold[AW-1:0];

    pfm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (GRID_MAX)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (w_sum),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc_coeff) begin
                    if (!r_job_open) begin
                        n_state = ST_START;
                    end else if (i_in.payload.last_coeff) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_START: begin
                if (w_mod_done) begin
                    n_state = r_first_last ? ST_DRAIN : ST_IDLE;
                end
            end
            // Let the final write-back land before the walk reads
            ST_DRAIN: n_state = ST_SCAN;
            ST_SCAN: begin
                if (!w_scan_in) begin
                    n_state = ST_FLUSH;
                end else if (w_scan_keep) begin
                    n_state = ST_DATA;
                end
            end
            ST_DATA: begin
                if (w_data_leave) begin
                    n_state = ST_SCAN;
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_period     <= PERIOD_RST;
            r_grid       <= GRID_RST;
            r_keep       <= '0;
            r_touch      <= '0;
            r_job_open   <= 1'b0;
            r_fold       <= '0;
            r_s1_valid   <= 1'b0;
            r_wr_valid   <= 1'b0;
            r_idx        <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PERIOD: r_period <= i_cfg_data;
                    CFG_GRID:   r_grid   <= i_cfg_data[GRID_W-1:0];
                    default:    ;
                endcase
            end

            // Keep bits: drop positions past the grid
            if (w_acc_mask && (32'(i_in.payload.position) < GRID_MAX)) begin
                r_keep[w_keep_addr] <= i_in.payload.mask_bit;
            end

            // Job start clears the written marks; write-back sets them
            if (w_mod_start) begin
                r_touch <= '0;
            end
            if (r_s1_valid) begin
                r_touch[r_s1_addr] <= 1'b1;
            end

            if ((r_state == ST_START) && w_mod_done) begin
                r_job_open <= !r_first_last;
            end else if (w_acc_coeff && r_job_open && i_in.payload.last_coeff) begin
                r_job_open <= 1'b0;
            end

            if (w_issue) begin
                r_fold <= w_fold_next;
            end

            r_s1_valid <= w_issue_hit;
            r_wr_valid <= r_s1_valid;

            // Walk index
            if (r_state == ST_DRAIN) begin
                r_idx <= '0;
            end else if ((r_state == ST_SCAN) && w_scan_in && !w_scan_keep) begin
                r_idx <= r_idx + IW'(1);
            end else if ((r_state == ST_DATA) && w_data_leave) begin
                r_idx <= r_idx + IW'(1);
            end

            // Hold register: fill on each kept value, empty at the flush
            if ((r_state == ST_DATA) && w_data_leave) begin
                r_hold_valid <= 1'b1;
            end else if ((r_state == ST_FLUSH) && w_out_free) begin
                r_hold_valid <= 1'b0;
            end

            // Output register: reload when a result moves in, drop on transfer
            if (((r_state == ST_DATA) && w_data_leave && r_hold_valid)
                    || ((r_state == ST_FLUSH) && w_out_free)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_mod_start) begin
            r_first_coeff <= i_in.payload.coeff;
            r_first_last  <= i_in.payload.last_coeff;
        end
        if (w_issue_hit) begin
            r_s1_addr  <= w_issue_fold[AW-1:0];
            r_s1_coeff <= w_issue_coeff;
        end
        if (r_s1_valid) begin
            r_wr_addr <= r_s1_addr;
            r_wr_data <= w_sum;
        end

        // A kept value waits in the hold register until the next kept one
        // shows up, so the final one can be marked last
        if ((r_state == ST_DATA) && w_data_leave) begin
            r_hold_value <= w_data_val;
            r_hold_pos   <= POS_W'(r_idx);
            if (r_hold_valid) begin
                r_out.value         <= r_hold_value;
                r_out.grid_position <= r_hold_pos;
                r_out.last          <= 1'b0;
                r_out.empty_res     <= 1'b0;
            end
        end else if ((r_state == ST_FLUSH) && w_out_free) begin
            if (r_hold_valid) begin
                r_out.value         <= r_hold_value;
                r_out.grid_position <= r_hold_pos;
                r_out.empty_res     <= 1'b0;
            end else begin
                r_out.value         <= '0;
                r_out.grid_position <= '0;
                r_out.empty_res     <= 1'b1;
            end
            r_out.last <= 1'b1;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_no_writeback_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !r_s1_valid)
        else $error("write-back pending while walk reads the accumulators");

    a_mod_done_in_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == ST_START))
        else $error("remainder unit finished outside job start");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.empty_res) |-> r_out.last)
        else $error("empty result not marked last");

endmodule

### bench/pfm_fold_checker.sv
`timescale 1ns / 100ps

module pfm_fold_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pfm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pfm_pkg::PER_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  pfm_pkg::t_in_item             i_in_item,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  pfm_pkg::t_out_item            i_out_item,
    input  logic                          i_end_check,
    output int                            o_outstanding,
    output int                            o_fail_count
);
    import pfm_pkg::*;

    localparam int GRID_DEPTH = 64;

    // Shadow of the block state
    logic [PER_W-1:0]        period_q;
    logic [GRID_W-1:0]       grid_q;
    logic signed [VAL_W-1:0] acc [GRID_DEPTH];
    logic                    keep [GRID_DEPTH];
    logic [FOLD_W-1:0]       fold_pos;
    logic                    job_open;

    t_out_item sums_q [$];   // folded sums still owed by the block
    t_out_item early_q [$];  // sums that showed up while their item was still held
    int        fails    = 0;
    bit        end_done = 1'b0;

    // Fields print as value/pos/last/empty
    task automatic check_sum(input t_out_item want, input t_out_item got);
        if (got !== want) begin
            $display("%0t: sum mismatch: expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
                     $time, want.value, want.grid_position, want.last, want.empty_res,
                     got.value, got.grid_position, got.last, got.empty_res);
            fails++;
        end
    endtask

    task automatic fold_item(input t_in_item it);
        int        p;
        int        g;
        int        half;
        int        d;
        int        r;
        int        n_kept;
        t_out_item res;
        if (period_q == '0) begin
            p = 1;
        end else if (period_q > PERIOD_LIM) begin
            p = int'(PERIOD_LIM);
        end else begin
            p = int'(period_q);
        end
        g = (int'(grid_q) > GRID_DEPTH) ? GRID_DEPTH : int'(grid_q);

        if (it.action == ACT_MASK) begin
            keep[it.position] = it.mask_bit;
            return;
        end

        if (!job_open) begin
            half = (it.coeff_count == '0) ? 0 : (int'(it.coeff_count) - 1) >>> 1;
            d    = int'(it.center_coord) - int'(it.lower_bound) - half;
            r    = d % p;
            if (r < 0) begin
                r += p;
            end
            for (int s = 0; s < GRID_DEPTH; s++) begin
                acc[s] = '0;
            end
            fold_pos = r[FOLD_W-1:0];
            job_open = 1'b1;
        end

        if (int'(fold_pos) < g) begin
            acc[fold_pos] = acc[fold_pos] + {{(VAL_W-COEF_W){it.coeff[COEF_W-1]}}, it.coeff};
        end
        if (int'(fold_pos) + 1 >= p) begin
            fold_pos = '0;
        end else begin
            fold_pos = fold_pos + 1'b1;
        end

        if (it.last_coeff) begin
            n_kept = 0;
            for (int s = 0; s < g; s++) begin
                if (keep[s]) begin
                    res.value         = acc[s];
                    res.grid_position = s[POS_W-1:0];
                    res.last          = 1'b0;
                    res.empty_res     = 1'b0;
                    sums_q.push_back(res);
                    n_kept++;
                end
            end
            if (n_kept == 0) begin
                res           = '0;
                res.last      = 1'b1;
                res.empty_res = 1'b1;
                sums_q.push_back(res);
            end else begin
                sums_q[sums_q.size()-1].last = 1'b1;
            end
            job_open = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            period_q = PERIOD_RST;
            grid_q   = GRID_RST;
            for (int s = 0; s < GRID_DEPTH; s++) begin
                acc[s]  = '0;
                keep[s] = 1'b0;
            end
            fold_pos = '0;
            job_open = 1'b0;
            sums_q.delete();
            early_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PERIOD) begin
                    period_q = i_cfg_data;
                end else if (i_cfg_idx == CFG_GRID) begin
                    grid_q = i_cfg_data[GRID_W-1:0];
                end
            end

            if (i_in_valid && i_in_ready) begin
                fold_item(i_in_item);
                while (early_q.size() != 0 && sums_q.size() != 0) begin
                    check_sum(sums_q.pop_front(), early_q.pop_front());
                end
                if (early_q.size() != 0) begin
                    $display("%0t: %0d sums arrived that the accepted item does not explain",
                             $time, early_q.size());
                    fails++;
                    early_q.delete();
                end
            end

            if (i_out_valid && i_out_ready) begin
                if (sums_q.size() != 0) begin
                    check_sum(sums_q.pop_front(), i_out_item);
                end else if (i_in_valid) begin
                    early_q.push_back(i_out_item);
                end else begin
                    $display("%0t: unexpected sum: expected none, got %0d/%0d/%0b/%0b",
                             $time, i_out_item.value, i_out_item.grid_position,
                             i_out_item.last, i_out_item.empty_res);
                    fails++;
                end
            end

            if (i_end_check && !end_done) begin
                end_done = 1'b1;
                if (sums_q.size() != 0 || early_q.size() != 0) begin
                    $display("%0t: at end: expected 0 open sums, got %0d missing and %0d unmatched",
                             $time, sums_q.size(), early_q.size());
                    fails++;
                end
            end
        end
        o_outstanding <= sums_q.size();
        o_fail_count  <= fails;
    end

endmodule

### bench/tb_periodic_fold_and_mask_compact.sv
`timescale 1ns / 100ps

module tb_periodic_fold_and_mask_compact;
    import pfm_pkg::*;

    // Longest stretch without any transfer before the run is declared hung.
    // Covers the start computation, the mask walk at full grid, deep stalls
    // on both sides and the quiet time before register writes.
    localparam int WATCHDOG_LIMIT = 4000;
    // Quiet cycles before a register write and at the very end: well past
    // the start computation of a first coefficient.
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 8;
    localparam int NUM_PHASES     = 8;

    localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [PER_W-1:0]     cfg_data;
    logic                 end_check;

    int src_idle_pct;
    int sink_stall_pct;
    int items_sent;
    int idle_cycles;
    int sums_pending;
    int fail_total;

    pfm_stream_if #(.T(t_in_item))  in_if ();
    pfm_stream_if #(.T(t_out_item)) out_if ();

    periodic_fold_and_mask_compact u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    pfm_fold_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_if.valid),
        .i_in_ready    (in_if.ready),
        .i_in_item     (in_if.payload),
        .i_out_valid   (out_if.valid),
        .i_out_ready   (out_if.ready),
        .i_out_item    (out_if.payload),
        .i_end_check   (end_check),
        .o_outstanding (sums_pending),
        .o_fail_count  (fail_total)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Result side: stall at the rate the current phase asks for.
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Watchdog: count cycles in which neither channel makes a transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired after %0d quiet cycles", $time, idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one item and hold it until the block takes it. Valid stays high
    // on return so a back-to-back item needs no second assignment.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= it;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // Load one keep bit; fill the unused fields with noise.
    task automatic send_mask(input logic [POS_W-1:0] pos, input logic keep_bit);
        t_in_item it;
        it.action       = ACT_MASK;
        it.position     = pos;
        it.mask_bit     = keep_bit;
        it.coeff        = $urandom;
        it.center_coord = COORD_W'($urandom_range(0, 65535));
        it.lower_bound  = COORD_W'($urandom_range(0, 65535));
        it.coeff_count  = CNT_W'($urandom_range(0, 127));
        it.last_coeff   = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    task automatic send_coeff(input logic signed [COEF_W-1:0] c,
                              input logic signed [COORD_W-1:0] ctr,
                              input logic signed [COORD_W-1:0] low,
                              input logic [CNT_W-1:0] cnt,
                              input logic last);
        t_in_item it;
        it.action       = ACT_COEFF;
        it.position     = POS_W'($urandom_range(0, 63));
        it.mask_bit     = 1'($urandom_range(0, 1));
        it.coeff        = c;
        it.center_coord = ctr;
        it.lower_bound  = low;
        it.coeff_count  = cnt;
        it.last_coeff   = last;
        send_item(it);
    endtask

    // Coefficients lean toward the extremes and small Q16.16 values.
    function automatic logic signed [COEF_W-1:0] rand_coeff();
        case ($urandom_range(0, 5))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2:       return 32'($urandom_range(0, 131071)) - 32'd65536;
            default: return $urandom;
        endcase
    endfunction

    // One well-formed job with random content; now and then a keep bit
    // changes in the middle of it.
    task automatic random_job(input int n_coeffs);
        for (int k = 0; k < n_coeffs; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_mask(POS_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            end
            send_coeff(rand_coeff(), COORD_W'($urandom_range(0, 65535)),
                       COORD_W'($urandom_range(0, 65535)),
                       CNT_W'($urandom_range(0, 127)), k == n_coeffs - 1);
        end
    endtask

    // Pile the same coefficient into one position until the sum wraps.
    task automatic flood_job(input logic signed [COEF_W-1:0] c, input int n_coeffs);
        for (int k = 0; k < n_coeffs; k++) begin
            send_coeff(c, 16'sd0, 16'sd0, 7'd1, k == n_coeffs - 1);
        end
    endtask

    // Drop valid and hold until every owed sum has been seen.
    task automatic drain_sums();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sums_pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write both registers once the block is quiet. Upper data bits of the
    // grid write are noise the register must drop.
    task automatic program_axis(input logic [PER_W-1:0] per, input logic [GRID_W-1:0] grd);
        drain_sums();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_PERIOD;
        cfg_data <= per;
        @(posedge i_clk);
        cfg_idx  <= CFG_GRID;
        cfg_data <= {6'($urandom_range(0, 63)), grd};
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        int phase_start;
        int per;
        int grd;

        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_PERIOD;
        cfg_data       = '0;
        end_check      = 1'b0;
        in_if.valid    = 1'b0;
        in_if.payload  = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        items_sent     = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset settings (period 64, grid 64).
        // No keep bit set yet: the job ends empty. Large start offset, largest half term.
        send_coeff(COEF_MAX, 16'sh7FFF, 16'sh8000, 7'd127, 1'b1);
        send_mask(6'd0, 1'b1);
        send_mask(6'd63, 1'b1);
        send_mask(6'd31, 1'b1);
        send_mask(6'd31, 1'b0);
        send_mask(6'd5, 1'b1);
        // Negative offset wraps to a positive start; zero count; keep bit
        // loaded in the middle of the job.
        send_coeff(COEF_MIN, 16'sh8000, 16'sh7FFF, 7'd0, 1'b0);
        send_mask(6'd2, 1'b1);
        send_coeff(-32'sd1, 16'sd0, 16'sd0, 7'd0, 1'b0);
        send_coeff(32'sd1, 16'sd0, 16'sd0, 7'd0, 1'b1);
        // Fold across the period end: 62, 63, 0, 1.
        send_coeff(-32'sd1, 16'sd62, 16'sd0, 7'd1, 1'b0);
        send_coeff(32'sd1, 16'sd0, 16'sd0, 7'd0, 1'b0);
        send_coeff(COEF_MIN, 16'sd0, 16'sd0, 7'd0, 1'b0);
        send_coeff(COEF_MAX, 16'sd0, 16'sd0, 7'd0, 1'b1);
        // Full-length count: half term of 31.
        send_coeff(32'sd12345, 16'sd0, 16'sd0, 7'd64, 1'b1);

        // Random phases, each with its own axis setting and idle pattern.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin per = 64;   grd = 64;  src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin per = 1;    grd = 1;   src_idle_pct = 88; sink_stall_pct = 0;  end
                2: begin per = 4096; grd = 64;  src_idle_pct = 0;  sink_stall_pct = 88; end
                3: begin per = 0;    grd = 0;   src_idle_pct = 10; sink_stall_pct = 10; end
                4: begin per = 8191; grd = 127; src_idle_pct = 0;  sink_stall_pct = 0;  end
                5: begin per = 5;    grd = 64;  src_idle_pct = 88; sink_stall_pct = 0;  end
                6: begin
                    per = $urandom_range(1, 4096);
                    grd = $urandom_range(1, 64);
                    src_idle_pct   = 0;
                    sink_stall_pct = 88;
                end
                default: begin per = 100; grd = 33; src_idle_pct = 10; sink_stall_pct = 10; end
            endcase
            program_axis(per[PER_W-1:0], grd[GRID_W-1:0]);
            phase_start = items_sent;

            // Period 1, grid 1: every coefficient lands on position 0, so
            // long runs of extremes wrap the accumulator both ways.
            if (ph == 1) begin
                send_mask(6'd0, 1'b1);
                flood_job(COEF_MAX, 66);
                flood_job(COEF_MIN, 65);
                phase_start = items_sent;
            end

            while (items_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_mask(POS_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
                end else if ($urandom_range(0, 9) == 0) begin
                    random_job($urandom_range(9, 70));
                end else begin
                    random_job($urandom_range(1, 8));
                end
                // Now and then let the result side run dry before going on.
                if (ph == 6 && $urandom_range(0, 3) == 0) begin
                    drain_sums();
                end
            end
        end

        // Wind down: wait for the last sums, then a quiet tail.
        drain_sums();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        end_check <= 1'b1;
        @(posedge i_clk);
        @(posedge i_clk);
        if (fail_total == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
src/pfm_pkg.sv
src/pfm_stream_if.sv
src/pfm_ram.sv
src/pfm_mod.sv
src/periodic_fold_and_mask_compact.sv
bench/pfm_fold_checker.sv
bench/tb_periodic_fold_and_mask_compact.sv
